@@ hw/rtl/htfd_pkg.sv @@
// Package for the humidity/temperature frame decoder.
// Holds the byte positions, the CRC-8 fold, the scaling constants and the job record.
// No dependencies.
package htfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Byte positions within a six-byte reply
    localparam logic [2:0] POS_TEMP_MSB  = 3'd0;
    localparam logic [2:0] POS_TEMP_LSB  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC  = 3'd2;
    localparam logic [2:0] POS_HUMID_MSB = 3'd3;
    localparam logic [2:0] POS_HUMID_LSB = 3'd4;
    localparam logic [2:0] POS_HUMID_CRC = 3'd5;

    // Scaling: spans, offset and limits in hundredths; FULL_SCALE in raw counts
    localparam logic [14:0] TEMP_SPAN     = 15'd17500;
    localparam logic [13:0] HUMID_SPAN    = 14'd10000;
    localparam logic [16:0] FULL_SCALE    = 17'd65535;
    localparam logic [30:0] TEMP_ZERO_MUL = 31'd294907500;   // 4500 * 65535
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
    localparam logic signed [15:0] TEMP_MAX    = 16'sd12500;
    localparam logic signed [15:0] TEMP_MIN    = -16'sd4000;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] humid_raw;
        logic        crc_ok;
    } job_t;

    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/htfd_front.sv @@
// Front part: takes reply bytes, tracks position, runs the CRC-8 and builds jobs.
// Depends on htfd_pkg.
module htfd_front
    import htfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       frame_start,
    output logic       push,
    output job_t       push_job
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_raw_reg, temp_raw_next;
    logic [15:0] humid_raw_reg, humid_raw_next;
    logic        temp_good_reg, temp_good_next;
    logic [2:0]  pos_eff;
    logic [7:0]  fold_init, fold_run;

    assign pos_eff   = (frame_start || (pos_reg > POS_HUMID_CRC)) ? POS_TEMP_MSB : pos_reg;
    assign fold_init = crc8_fold(CRC_INIT, rx_byte);
    assign fold_run  = crc8_fold(crc_reg, rx_byte);

    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_raw_next  = temp_raw_reg;
        humid_raw_next = humid_raw_reg;
        temp_good_next = temp_good_reg;
        push           = 1'b0;
        if (accept)
        begin
            pos_next = pos_eff + 3'd1;
            case (pos_eff)
                POS_TEMP_MSB:
                begin
                    crc_next      = fold_init;
                    temp_raw_next = {rx_byte, 8'h00};
                end
                POS_TEMP_LSB:
                begin
                    crc_next      = fold_run;
                    temp_raw_next = {temp_raw_reg[15:8], rx_byte};
                end
                POS_TEMP_CRC:
                begin
                    temp_good_next = (crc_reg == rx_byte);
                end
                POS_HUMID_MSB:
                begin
                    crc_next       = fold_init;
                    humid_raw_next = {rx_byte, 8'h00};
                end
                POS_HUMID_LSB:
                begin
                    crc_next       = fold_run;
                    humid_raw_next = {humid_raw_reg[15:8], rx_byte};
                end
                default:
                begin
                    // sixth byte: wrap and hand the frame over
                    pos_next = POS_TEMP_MSB;
                    crc_next = CRC_INIT;
                    push     = 1'b1;
                end
            endcase
        end
    end

    assign push_job.temp_raw  = temp_raw_reg;
    assign push_job.humid_raw = humid_raw_reg;
    assign push_job.crc_ok    = temp_good_reg && (crc_reg == rx_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_TEMP_MSB;
            crc_reg       <= CRC_INIT;
            temp_raw_reg  <= 16'd0;
            humid_raw_reg <= 16'd0;
            temp_good_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_raw_reg  <= temp_raw_next;
            humid_raw_reg <= humid_raw_next;
            temp_good_reg <= temp_good_next;
        end
    end

endmodule

@@ hw/rtl/htfd_queue.sv @@
// Short job queue between the front and back parts.
// Depends on htfd_pkg.
module htfd_queue
    import htfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic pop_valid,
    output job_t pop_job,
    input  logic pop
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/htfd_back.sv @@
// Back part: scales a frame to hundredths, keeps the last good values, holds the result.
// Depends on htfd_pkg. Stage 1 multiplies, stage 2 divides by full scale and clamps.
module htfd_back
    import htfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  job_t               job,
    output logic               job_pop,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [14:0] temperature_centi,
    output logic [13:0]        humidity_centi,
    output logic               check_failed
);

    logic        s1_valid_reg, s1_valid_next;
    logic [30:0] s1_tmul_reg;
    logic [29:0] s1_hmul_reg;
    logic        s1_ok_reg;
    logic        out_valid_reg, out_valid_next;
    logic signed [14:0] temp_reg, last_temp_reg;
    logic [13:0] humid_reg, last_humid_reg;
    logic        fail_reg;
    logic        s2_load, s1_load;

    // divide-by-65535 pieces
    logic [14:0] tq0, tq;
    logic [16:0] tr;
    logic        t_ge, t_rem_nz, t_adj;
    logic signed [15:0] t_val, t_clamp;
    logic [13:0] hq0, hq;
    logic [16:0] hr;

    assign s2_load = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign s1_load = !s1_valid_reg || s2_load;
    assign job_pop = job_valid && s1_load;

    always_comb
    begin
        // q0 = x >> 16, remainder estimate x - 65535*q0 = low half + q0
        tq0      = s1_tmul_reg[30:16];
        tr       = {1'b0, s1_tmul_reg[15:0]} + {2'b00, tq0};
        t_ge     = (tr >= FULL_SCALE);
        tq       = tq0 + {14'd0, t_ge};
        t_rem_nz = t_ge ? (tr != FULL_SCALE) : (tr != 17'd0);
        // negative numerator truncates toward zero: round the quotient up
        t_adj    = (s1_tmul_reg < TEMP_ZERO_MUL) && t_rem_nz;
        t_val    = $signed({1'b0, tq}) - TEMP_OFFSET + $signed({15'd0, t_adj});
        if (t_val > TEMP_MAX)
        begin
            t_clamp = TEMP_MAX;
        end
        else if (t_val < TEMP_MIN)
        begin
            t_clamp = TEMP_MIN;
        end
        else
        begin
            t_clamp = t_val;
        end
        hq0 = s1_hmul_reg[29:16];
        hr  = {1'b0, s1_hmul_reg[15:0]} + {3'b000, hq0};
        hq  = hq0 + {13'd0, (hr >= FULL_SCALE)};
    end

    always_comb
    begin
        s1_valid_next  = s1_load ? job_valid : s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s2_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_tmul_reg <= {15'd0, job.temp_raw} * {16'd0, TEMP_SPAN};
            s1_hmul_reg <= {14'd0, job.humid_raw} * {16'd0, HUMID_SPAN};
            s1_ok_reg   <= job.crc_ok;
        end
        if (s2_load)
        begin
            fail_reg <= !s1_ok_reg;
            if (s1_ok_reg)
            begin
                temp_reg  <= t_clamp[14:0];
                humid_reg <= hq;
            end
            else
            begin
                temp_reg  <= last_temp_reg;
                humid_reg <= last_humid_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_temp_reg  <= '0;
            last_humid_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s2_load && s1_ok_reg)
            begin
                last_temp_reg  <= t_clamp[14:0];
                last_humid_reg <= hq;
            end
        end
    end

    assign result_valid      = out_valid_reg;
    assign temperature_centi = temp_reg;
    assign humidity_centi    = humid_reg;
    assign check_failed      = fail_reg;

endmodule

@@ hw/rtl/humidity_temp_frame_decoder_top.sv @@
// A reply is queued with its sixth byte, then passes the back part's multiply and divide/clamp registers.
// Throughput: one byte per cycle while byte_stall is low; one result per six bytes, set by reply length.
// The job queue (two entries) lets the front keep taking bytes while a result is stalled;
// byte_stall rises only when the queue is full.
// Reset (rst_n, asynchronous, active low): position 0, CRC 0xFF, last good values zero,
// queue and back pipeline empty.
module humidity_temp_frame_decoder_top
    import htfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [14:0] temperature_centi,
    output logic [13:0]        humidity_centi,
    output logic               check_failed
);

    logic accept;
    logic q_push, q_full, q_valid, q_pop;
    job_t q_in_job, q_out_job;

    // hold the byte source off while the queue has no room
    assign byte_stall = q_full;
    assign accept     = byte_valid && !byte_stall;

    // front: position, CRC and raw words; push one job per completed reply
    htfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .push        (q_push),
        .push_job    (q_in_job)
    );

    // queue: decouple the byte side from the result side
    htfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_in_job),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_job   (q_out_job),
        .pop       (q_pop)
    );

    // back: scale, keep last good values, drive the result word
    htfd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .job_valid         (q_valid),
        .job               (q_out_job),
        .job_pop           (q_pop),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .check_failed      (check_failed)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("job pushed into a full queue");

    a_humid_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (humidity_centi <= 14'd10000))
        else $error("humidity out of range");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (($signed(temperature_centi) >= -15'sd4000)
                          && ($signed(temperature_centi) <= 15'sd12500)))
        else $error("temperature out of clamp range");
`endif

endmodule
